// ----- hw/rtl/lsr_pkg.sv -----
`default_nettype none
package lsr_pkg;

    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_MAX_HEIGHT   = 128;
    localparam int DEF_MAX_WIDTH    = 128;
    localparam int DEF_ACC_DEPTH    = 16384;

    localparam int SUM_W     = 50;
    localparam int SQ_STEPS  = 28;
    localparam int ADDR_W    = 4;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic [1:0] REG_AXIS_MODE = 2'd0;
    localparam logic [1:0] REG_CHANNELS  = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;
    localparam logic [1:0] REG_WIDTH     = 2'd3;

    localparam logic [1:0] MODE_CHAN = 2'd0;
    localparam logic [1:0] MODE_ROW  = 2'd1;
    localparam logic [1:0] MODE_COL  = 2'd2;
    localparam logic [1:0] MODE_ALL  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHK,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_ADJ,
        ST_MAG,
        ST_SCL,
        ST_RND,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic acc;
        logic norm_load;
        logic norm_step;
        logic sq_mul;
        logic sq_adj;
        logic mag;
        logic scl;
        logic rnd;
        logic fin;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;
        logic bad;
        logic norm_done;
        logic sq_last;
        logic out_busy;
    } ctrl_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lsr_ram.sv -----
`default_nettype none
module lsr_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 16384
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lsr_datapath.sv -----
`default_nettype none
module lsr_datapath #(
    parameter int MAX_CHANNELS = lsr_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = lsr_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = lsr_pkg::DEF_MAX_WIDTH,
    parameter int ACC_DEPTH    = lsr_pkg::DEF_ACC_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lsr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    input  wire logic signed [31:0]          s_sample,
    input  wire lsr_pkg::ctrl_cmd_t          cmd,
    output lsr_pkg::ctrl_sts_t               sts,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [31:0]               m_log_value,
    output logic                             m_not_positive,
    output logic      [13:0]                 m_result_index,
    output logic                             m_last_result
);

    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(ACC_DEPTH);
    localparam int SW = lsr_pkg::SUM_W;

    logic [1:0] mode_reg;
    logic [4:0] chan_cfg_reg;
    logic [7:0] height_cfg_reg;
    logic [7:0] width_cfg_reg;

    logic [CW-1:0] chan_reg;
    logic [HW-1:0] row_reg;
    logic [WW-1:0] col_reg;
    logic [13:0]   out_cnt_reg;

    logic [CW-1:0] nc;
    logic [HW-1:0] nh;
    logic [WW-1:0] nw;

    logic          cfg_wr;
    logic [31:0]   idx_full;
    logic          first_c;
    logic          emit_c;
    logic          last_c;

    logic signed [31:0] sample_reg;
    logic [AW-1:0]      idx_reg;
    logic               first_reg;
    logic               emit_reg;
    logic               last_reg;
    logic [SW-1:0]      sum_reg;
    logic [SW-1:0]      sum_c;
    logic [SW-1:0]      rdata;

    logic [48:0] nrm_reg;
    logic [5:0]  e_reg;
    logic [30:0] m_reg;
    logic [61:0] prod_reg;
    logic [27:0] f_reg;
    logic [4:0]  cnt_reg;
    logic [33:0] mag_reg;
    logic        neg_reg;
    logic [63:0] sp_reg;
    logic [31:0] lv_reg;
    logic [31:0] sq_t;
    logic [63:0] rnd_sum;

    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        if (chan_cfg_reg == 5'd0) begin
            nc = CW'(1);
        end else if (32'(chan_cfg_reg) > 32'(MAX_CHANNELS)) begin
            nc = CW'(MAX_CHANNELS);
        end else begin
            nc = CW'(chan_cfg_reg);
        end
        if (height_cfg_reg == 8'd0) begin
            nh = HW'(1);
        end else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT)) begin
            nh = HW'(MAX_HEIGHT);
        end else begin
            nh = HW'(height_cfg_reg);
        end
        if (width_cfg_reg == 8'd0) begin
            nw = WW'(1);
        end else if (32'(width_cfg_reg) > 32'(MAX_WIDTH)) begin
            nw = WW'(MAX_WIDTH);
        end else begin
            nw = WW'(width_cfg_reg);
        end
    end

    always_comb begin
        last_c = (chan_reg == nc - CW'(1)) && (row_reg == nh - HW'(1))
              && (col_reg == nw - WW'(1));
        unique case (mode_reg)
            lsr_pkg::MODE_CHAN: begin
                idx_full = 32'(row_reg) * 32'(nw) + 32'(col_reg);
                first_c  = (chan_reg == CW'(0));
                emit_c   = (chan_reg == nc - CW'(1));
            end
            lsr_pkg::MODE_ROW: begin
                idx_full = 32'(chan_reg) * 32'(nw) + 32'(col_reg);
                first_c  = (row_reg == HW'(0));
                emit_c   = (row_reg == nh - HW'(1));
            end
            lsr_pkg::MODE_COL: begin
                idx_full = 32'(chan_reg) * 32'(nh) + 32'(row_reg);
                first_c  = (col_reg == WW'(0));
                emit_c   = (col_reg == nw - WW'(1));
            end
            default: begin
                idx_full = 32'd0;
                first_c  = (chan_reg == CW'(0)) && (row_reg == HW'(0))
                        && (col_reg == WW'(0));
                emit_c   = last_c;
            end
        endcase
    end

    always_comb begin
        unique case (paddr[3:2])
            lsr_pkg::REG_AXIS_MODE: prdata = {30'd0, mode_reg};
            lsr_pkg::REG_CHANNELS:  prdata = {27'd0, chan_cfg_reg};
            lsr_pkg::REG_HEIGHT:    prdata = {24'd0, height_cfg_reg};
            default:                prdata = {24'd0, width_cfg_reg};
        endcase
    end

    assign sum_c = first_reg ? SW'(sample_reg) : rdata + SW'(sample_reg);

    lsr_ram #(
        .WIDTH (SW),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (cmd.acc),
        .waddr (idx_reg),
        .wdata (sum_c),
        .re    (cmd.accept),
        .raddr (idx_full[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= lsr_pkg::MODE_COL;
            chan_cfg_reg   <= 5'd16;
            height_cfg_reg <= 8'd112;
            width_cfg_reg  <= 8'd112;
            chan_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            out_cnt_reg    <= '0;
            m_valid        <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    lsr_pkg::REG_AXIS_MODE: mode_reg       <= pwdata[1:0];
                    lsr_pkg::REG_CHANNELS:  chan_cfg_reg   <= pwdata[4:0];
                    lsr_pkg::REG_HEIGHT:    height_cfg_reg <= pwdata[7:0];
                    default:                width_cfg_reg  <= pwdata[7:0];
                endcase
                chan_reg    <= '0;
                row_reg     <= '0;
                col_reg     <= '0;
                out_cnt_reg <= '0;
            end else if (cmd.acc) begin
                if (last_reg) begin
                    chan_reg <= '0;
                    row_reg  <= '0;
                    col_reg  <= '0;
                end else if (col_reg == nw - WW'(1)) begin
                    col_reg <= '0;
                    if (row_reg == nh - HW'(1)) begin
                        row_reg  <= '0;
                        chan_reg <= chan_reg + CW'(1);
                    end else begin
                        row_reg <= row_reg + HW'(1);
                    end
                end else begin
                    col_reg <= col_reg + WW'(1);
                end
            end
            if (cmd.fin) begin
                m_valid     <= 1'b1;
                out_cnt_reg <= last_reg ? 14'd0 : out_cnt_reg + 14'd1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    assign sq_t    = prod_reg[61:30];
    assign rnd_sum = sp_reg + (64'd1 << 33);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= s_sample;
            idx_reg    <= idx_full[AW-1:0];
            first_reg  <= first_c;
            emit_reg   <= emit_c;
            last_reg   <= last_c;
        end
        if (cmd.acc) begin
            sum_reg <= sum_c;
        end
        if (cmd.norm_load) begin
            nrm_reg <= sum_reg[48:0];
            e_reg   <= 6'd48;
        end else if (cmd.norm_step) begin
            if (!nrm_reg[48]) begin
                nrm_reg <= {nrm_reg[47:0], 1'b0};
                e_reg   <= e_reg - 6'd1;
            end else begin
                m_reg   <= nrm_reg[48:18];
                f_reg   <= '0;
                cnt_reg <= '0;
            end
        end
        if (cmd.sq_mul) begin
            prod_reg <= {31'd0, m_reg} * {31'd0, m_reg};
        end
        if (cmd.sq_adj) begin
            f_reg   <= {f_reg[26:0], sq_t[31]};
            m_reg   <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (cmd.mag) begin
            if (e_reg >= 6'd16) begin
                mag_reg <= {e_reg - 6'd16, 28'd0} + {6'd0, f_reg};
                neg_reg <= 1'b0;
            end else begin
                mag_reg <= {6'd16 - e_reg, 28'd0} - {6'd0, f_reg};
                neg_reg <= 1'b1;
            end
        end
        if (cmd.scl) begin
            sp_reg <= {30'd0, mag_reg} * {34'd0, lsr_pkg::LN2_Q30};
        end
        if (cmd.rnd) begin
            lv_reg <= neg_reg ? 32'd0 - {2'd0, rnd_sum[63:34]} : {2'd0, rnd_sum[63:34]};
        end
        if (cmd.fin) begin
            m_log_value    <= sts.bad ? 32'sd0 : $signed(lv_reg);
            m_not_positive <= sts.bad;
            m_result_index <= out_cnt_reg;
            m_last_result  <= last_reg;
        end
    end

    assign sts.emit      = emit_reg;
    assign sts.bad       = (sum_reg == '0) || sum_reg[SW-1];
    assign sts.norm_done = nrm_reg[48];
    assign sts.sq_last   = (cnt_reg == 5'(lsr_pkg::SQ_STEPS - 1));
    assign sts.out_busy  = m_valid & ~m_ready;

endmodule
`default_nettype wire

// ----- hw/rtl/lsr_ctrl.sv -----
`default_nettype none
module lsr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lsr_pkg::ctrl_sts_t sts,
    output lsr_pkg::ctrl_cmd_t      cmd
);

    lsr_pkg::state_t state_reg;
    lsr_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsr_pkg::ST_IDLE: begin
                if (s_valid) state_next = lsr_pkg::ST_ACC;
            end
            lsr_pkg::ST_ACC: state_next = lsr_pkg::ST_CHK;
            lsr_pkg::ST_CHK: begin
                if (!sts.emit) begin
                    state_next = lsr_pkg::ST_IDLE;
                end else if (sts.bad) begin
                    state_next = lsr_pkg::ST_FIN;
                end else begin
                    state_next = lsr_pkg::ST_NORM;
                end
            end
            lsr_pkg::ST_NORM: begin
                if (sts.norm_done) state_next = lsr_pkg::ST_SQ_MUL;
            end
            lsr_pkg::ST_SQ_MUL: state_next = lsr_pkg::ST_SQ_ADJ;
            lsr_pkg::ST_SQ_ADJ: begin
                state_next = sts.sq_last ? lsr_pkg::ST_MAG : lsr_pkg::ST_SQ_MUL;
            end
            lsr_pkg::ST_MAG: state_next = lsr_pkg::ST_SCL;
            lsr_pkg::ST_SCL: state_next = lsr_pkg::ST_RND;
            lsr_pkg::ST_RND: state_next = lsr_pkg::ST_FIN;
            lsr_pkg::ST_FIN: begin
                if (!sts.out_busy) state_next = lsr_pkg::ST_IDLE;
            end
            default: state_next = lsr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            lsr_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            lsr_pkg::ST_ACC:    cmd.acc = 1'b1;
            lsr_pkg::ST_CHK:    cmd.norm_load = sts.emit & ~sts.bad;
            lsr_pkg::ST_NORM:   cmd.norm_step = 1'b1;
            lsr_pkg::ST_SQ_MUL: cmd.sq_mul = 1'b1;
            lsr_pkg::ST_SQ_ADJ: cmd.sq_adj = 1'b1;
            lsr_pkg::ST_MAG:    cmd.mag = 1'b1;
            lsr_pkg::ST_SCL:    cmd.scl = 1'b1;
            lsr_pkg::ST_RND:    cmd.rnd = 1'b1;
            lsr_pkg::ST_FIN:    cmd.fin = ~sts.out_busy;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    a_acc_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsr_pkg::ST_ACC) |-> $past(s_valid && s_ready))
        else $error("accumulate without an accepted beat");

    a_adj_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsr_pkg::ST_SQ_ADJ) |-> $past(state_reg == lsr_pkg::ST_SQ_MUL))
        else $error("square adjust without a product");

    a_fin_not_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> !sts.out_busy)
        else $error("result loaded over a pending beat");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command");

endmodule
`default_nettype wire

// ----- hw/rtl/tensor_axis_log_sum_reduce_top.sv -----
// Log-sum reduction of a CHW tensor streamed one element per beat.
// Input channel s_valid/s_ready/s_sample carries signed Q16.16 elements in
// channel, row, column order. Result channel m_* carries ln of each finished
// sum in signed Q8.24, a not-positive flag, the result's index in the
// reduced tensor and a last-result mark. The APB port sets axis_mode,
// channels, height and width at byte addresses 0, 4, 8 and 12; any write
// restarts the tensor.
// One element is worked at a time. An element that finishes no sum passes
// through accept, read-add-write to the accumulator RAM and check. An
// element that finishes a positive sum adds the log unit: normalization
// one bit at a time, 28 squarings of a multiply and an adjust each, then
// magnitude, scaling, rounding and output load. A not-positive sum goes
// straight to the output register.
// The output register frees the input side once loaded; a stalled receiver
// holds a finishing element in its output-load cycle until the beat leaves.
// Reset (aresetn low, synchronous) restores the default configuration and
// tensor position; the accumulator RAM is not cleared, each sum starts fresh
// on its first element.
`default_nettype none
module tensor_axis_log_sum_reduce_top #(
    parameter int MAX_CHANNELS = lsr_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = lsr_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = lsr_pkg::DEF_MAX_WIDTH,
    parameter int ACC_DEPTH    = lsr_pkg::DEF_ACC_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lsr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [31:0]         s_sample,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [31:0]              m_log_value,
    output logic                            m_not_positive,
    output logic      [13:0]                m_result_index,
    output logic                            m_last_result
);

    lsr_pkg::ctrl_cmd_t cmd;
    lsr_pkg::ctrl_sts_t sts;

    assign pready = 1'b1;

    lsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lsr_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .ACC_DEPTH    (ACC_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .s_sample       (s_sample),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_log_value    (m_log_value),
        .m_not_positive (m_not_positive),
        .m_result_index (m_result_index),
        .m_last_result  (m_last_result)
    );

endmodule
`default_nettype wire

// ----- tb/tensor_axis_log_sum_reduce_top_tb.sv -----
`default_nettype none
module tensor_axis_log_sum_reduce_top_tb;
    import lsr_pkg::*;

    typedef struct packed {
        logic [31:0] log_value;
        logic        not_positive;
        logic [13:0] result_index;
        logic        last_result;
    } lsr_result_t;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic signed [31:0]  s_sample;
    logic                m_valid;
    logic                m_ready;
    logic signed [31:0]  m_log_value;
    logic                m_not_positive;
    logic [13:0]         m_result_index;
    logic                m_last_result;

    tensor_axis_log_sum_reduce_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_log_value(m_log_value),
        .m_not_positive(m_not_positive), .m_result_index(m_result_index),
        .m_last_result(m_last_result)
    );

    // Predictor state
    logic [SUM_W-1:0] acc_sums [DEF_ACC_DEPTH];
    logic [1:0]       cfg_mode;
    logic [4:0]       cfg_chan;
    logic [7:0]       cfg_height;
    logic [7:0]       cfg_width;
    int unsigned      pos_c, pos_r, pos_w, result_cnt;

    logic signed [31:0] sample_q[$];
    lsr_result_t        expected_q[$];

    int  err_cnt;
    int  idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [31:0] ln_q824(input logic [63:0] s);
        int unsigned      e;
        logic [63:0]      m;
        logic [127:0]     sq;
        logic [31:0]      f;
        logic [63:0]      mag;
        logic [127:0]     prod;
        logic [63:0]      r;
        logic             neg;
        e = 0;
        while (e < 63 && (s >> (e + 1)) != 0) e++;
        if (e >= 30) m = s >> (e - 30);
        else m = s << (30 - e);
        f = 0;
        for (int i = 0; i < SQ_STEPS; i++) begin
            sq = (128'(m) * 128'(m)) >> 30;
            m  = sq[63:0];
            f  = f << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                f[0] = 1'b1;
            end
        end
        if (e >= 16) begin
            neg = 1'b0;
            mag = (64'(e - 16) << 28) + 64'(f);
        end else begin
            neg = 1'b1;
            mag = (64'(16 - e) << 28) - 64'(f);
        end
        prod = 128'(mag) * 128'(LN2_Q30);
        r = 64'((prod + (128'd1 << 33)) >> 34);
        if (neg) r = 64'd0 - r;
        return r[31:0];
    endfunction

    task automatic restart_tensor();
        pos_c = 0; pos_r = 0; pos_w = 0; result_cnt = 0;
    endtask

    task automatic predict_element(input logic signed [31:0] smp);
        int unsigned      nc, nh, nw, idx;
        logic             first, emit, last, bad;
        logic [SUM_W-1:0] sum;
        lsr_result_t      res;
        nc = clamp_dim(cfg_chan, DEF_MAX_CHANNELS);
        nh = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
        nw = clamp_dim(cfg_width, DEF_MAX_WIDTH);
        last = (pos_c == nc - 1) && (pos_r == nh - 1) && (pos_w == nw - 1);
        case (cfg_mode)
            MODE_CHAN: begin
                idx = pos_r * nw + pos_w; first = (pos_c == 0); emit = (pos_c == nc - 1);
            end
            MODE_ROW: begin
                idx = pos_c * nw + pos_w; first = (pos_r == 0); emit = (pos_r == nh - 1);
            end
            MODE_COL: begin
                idx = pos_c * nh + pos_r; first = (pos_w == 0); emit = (pos_w == nw - 1);
            end
            default: begin
                idx = 0; first = (pos_c == 0) && (pos_r == 0) && (pos_w == 0); emit = last;
            end
        endcase
        idx = idx % DEF_ACC_DEPTH;
        sum = first ? SUM_W'(smp) : acc_sums[idx] + SUM_W'(smp);
        acc_sums[idx] = sum;
        if (emit) begin
            bad = (sum == 0) || sum[SUM_W-1];
            res.log_value    = bad ? 32'd0 : ln_q824(64'(sum));
            res.not_positive = bad;
            res.result_index = result_cnt[13:0];
            res.last_result  = last;
            expected_q.push_back(res);
            result_cnt = last ? 0 : ((result_cnt + 1) & 14'h3FFF);
        end
        pos_w++;
        if (pos_w >= nw) begin
            pos_w = 0; pos_r++;
            if (pos_r >= nh) begin
                pos_r = 0; pos_c++;
                if (pos_c >= nc) pos_c = 0;
            end
        end
        if (last) restart_tensor();
    endtask

    // Driver: bursts and gaps
    int  burst_left;
    int  gap_left;
    bit  hold_send;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_sample   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready) predict_element(s_sample);
            if (s_valid && !s_ready) begin
                // hold
            end else if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (!hold_send && sample_q.size() > 0) begin
                s_valid  <= 1'b1;
                s_sample <= sample_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: own stall pattern plus a long hold-off on request
    int  stall_mode;
    int  stall_phase;
    int  holdoff_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                m_ready      <= 1'b0;
            end else case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= (stall_phase % 5) < 3;
                default: m_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor
    always @(posedge aclk) begin
        lsr_result_t got;
        lsr_result_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                got = {m_log_value, m_not_positive, m_result_index, m_last_result};
                if (expected_q.size() == 0) begin
                    err_cnt <= err_cnt + 1;
                    if (err_cnt < 10) $display("unexpected result beat %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        err_cnt <= err_cnt + 1;
                        if (err_cnt < 10) begin
                            $display("mismatch: exp log=%h np=%b idx=%0d last=%b",
                                     want.log_value, want.not_positive,
                                     want.result_index, want.last_result);
                            $display("          got log=%h np=%b idx=%0d last=%b",
                                     got.log_value, got.not_positive,
                                     got.result_index, got.last_result);
                        end
                    end
                end
            end
            if (idle_cycles > 20000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (sample_q.size() > 0 || s_valid || expected_q.size() > 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({reg_idx, 2'b00}); pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (reg_idx)
            REG_AXIS_MODE: cfg_mode   = value[1:0];
            REG_CHANNELS:  cfg_chan   = value[4:0];
            REG_HEIGHT:    cfg_height = value[7:0];
            default:       cfg_width  = value[7:0];
        endcase
        restart_tensor();
    endtask

    task automatic set_shape(input logic [1:0] mode, input int c, input int h, input int w);
        wait_drained();
        apb_write(REG_AXIS_MODE, 32'(mode));
        apb_write(REG_CHANNELS, 32'(c));
        apb_write(REG_HEIGHT, 32'(h));
        apb_write(REG_WIDTH, 32'(w));
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return -$signed(32'($urandom_range(0, 32'h0003_0000)));
            default: return 32'($urandom_range(1, 32'h0100_0000));
        endcase
    endfunction

    task automatic queue_tensors(input int n);
        for (int i = 0; i < n; i++) sample_q.push_back(rand_sample());
    endtask

    initial begin
        int total;
        int nc, nh, nw;
        int n;
        bit paused;
        err_cnt = 0; idle_cycles = 0; holdoff_left = 0; stall_mode = 0; hold_send = 0;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_sample = '0; m_ready = 1'b0;
        cfg_mode = MODE_COL; cfg_chan = 5'd16; cfg_height = 8'd112; cfg_width = 8'd112;
        restart_tensor();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes in mode all, zero dims act as 1
        set_shape(MODE_ALL, 0, 0, 0);
        sample_q.push_back(32'sh7FFF_FFFF);
        sample_q.push_back(32'sh0000_0001);
        sample_q.push_back(32'sh8000_0000);
        sample_q.push_back(32'sh0000_0000);
        sample_q.push_back(32'sh0001_0000);
        sample_q.push_back(32'shFFFF_FFFF);
        // dims above max clamp; partial tensor then restart by write
        set_shape(MODE_CHAN, 31, 2, 2);
        queue_tensors(10);
        set_shape(MODE_ROW, 2, 255, 1);
        queue_tensors(4);
        set_shape(MODE_COL, 2, 2, 3);
        queue_tensors(12);
        set_shape(MODE_ALL, 1, 1, 2);
        sample_q.push_back(32'sh4000_0000);
        sample_q.push_back(32'sh4000_0000);

        // long hold-off with sender still pushing
        set_shape(MODE_CHAN, 1, 2, 4);
        stall_mode = 0;
        holdoff_left = 400;
        queue_tensors(16);
        wait_drained();

        total = 0;
        paused = 1'b0;
        while (total < 400) begin
            nc = $urandom_range(0, 4);
            nh = $urandom_range(0, 4);
            nw = $urandom_range(0, 5);
            if ($urandom_range(0, 7) == 0) begin
                nc = 1; nh = 1; nw = 128;
            end
            stall_mode = $urandom_range(0, 2);
            set_shape(2'($urandom_range(0, 3)), nc, nh, nw);
            nc = clamp_dim(nc, 16); nh = clamp_dim(nh, 128); nw = clamp_dim(nw, 128);
            n = nc * nh * nw * ((nw == 128) ? 1 : $urandom_range(1, 2))
                + (($urandom_range(0, 4) == 0) ? 3 : 0);
            queue_tensors(n);
            total += n;
            if (!paused && total > 200) begin
                paused = 1'b1;
                repeat (20) @(posedge aclk);
                hold_send = 1;
                while (expected_q.size() > 0) @(posedge aclk);
                hold_send = 0;
            end
        end
        wait_drained();
        if (err_cnt == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
